>>> design/modbus_read_response_checker_macros.svh
// Assertion helpers for the read response checker.
`ifndef MODBUS_READ_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_READ_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, reset-gated.
`define MRRC_ASSERT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-gated.
`define MRRC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mrrc_pkg.sv
package mrrc_pkg;

  localparam int MaxRegs = 16;
  localparam int IdxW    = $clog2(MaxRegs);
  localparam int CntW    = 5;

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  // Result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadLen   = 3'd1;
  localparam logic [2:0] StBadFunc  = 3'd2;
  localparam logic [2:0] StBadCount = 3'd3;
  localparam logic [2:0] StBadCrc   = 3'd4;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctrl_t;

  // Clamp the configured register count into 1..MaxRegs
  function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] raw);
    logic [CntW-1:0] res;
    if (raw == '0) begin
      res = CntW'(1);
    end else if (raw > CntW'(MaxRegs)) begin
      res = CntW'(MaxRegs);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  // One reflected CRC-16 bit step
  function automatic logic [15:0] crc_shift(input logic [15:0] c);
    logic [15:0] res;
    res = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return res;
  endfunction

endpackage

>>> design/mrrc_rx_if.sv
interface mrrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, rx_byte, end_of_frame, input ready);
  modport sink   (input valid, rx_byte, end_of_frame, output ready);
endinterface

>>> design/mrrc_res_if.sv
interface mrrc_res_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                device_address;
  logic [mrrc_pkg::IdxW-1:0] register_index;
  logic [15:0]               register_value;
  logic [2:0]                status;
  logic                      last;

  modport source (output valid, device_address, register_index, register_value, status, last,
                  input ready);
  modport sink   (input valid, device_address, register_index, register_value, status, last,
                  output ready);
endinterface

>>> design/mrrc_cfg_if.sv
interface mrrc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mrrc_pkg::CntW-1:0] register_count;

  modport source (output valid, register_count, input ready);
  modport sink   (input valid, register_count, output ready);
endinterface

>>> design/mrrc_crc_unit.sv
module mrrc_crc_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrrc_pkg::crc_ctrl_t ctrl_i,
  output logic                busy_o,
  output logic [15:0]         crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  // Fold in one byte with its first shift, then shift one bit per cycle until all eight bits are done
  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      crc_d  = mrrc_pkg::CrcInit;
      busy_d = 1'b0;
    end else if (ctrl_i.start) begin
      crc_d  = mrrc_pkg::crc_shift(crc_q ^ {8'h00, ctrl_i.data});
      cnt_d  = 3'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d  = mrrc_pkg::crc_shift(crc_q);
      cnt_d  = cnt_q - 3'd1;
      busy_d = (cnt_q != 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= mrrc_pkg::CrcInit;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

>>> design/mrrc_word_buf.sv
module mrrc_word_buf (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mrrc_pkg::IdxW-1:0] waddr_i,
  input  logic [15:0]               wdata_i,
  input  logic [mrrc_pkg::IdxW-1:0] raddr_i,
  output logic [15:0]               rdata_o
);

  logic [15:0] mem_q [mrrc_pkg::MaxRegs];
  logic [15:0] rdata_q;

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/modbus_read_response_checker.sv
// Modbus RTU read-holding-registers reply checker.
// rx_i takes one frame byte per request, end_of_frame set on the last byte.
// cfg_i writes register_count (N, clamped to 1..16); it is always ready and
// must only be written between frames while no results are pending.
// res_o gives N results (address, index, word, status ok) for a good frame,
// or one error result (bad length, function, byte count or CRC) otherwise.
// The first two bytes of a frame are taken straight from idle; every later
// byte goes through the bit-serial CRC unit (8 shift steps), and no new byte
// is taken until the sequencer is idle again. The frame is checked after its
// last byte; each good result then passes the registered word buffer read.
// Results sit in an output register; while res_o stalls, the next byte is
// still accepted once the sequencer is idle again, and the sequencer waits
// only when it has a new result and the register is still full.
// Reset: register_count returns to 1, all per-frame state clears, the CRC
// restarts at 0xFFFF. The word buffer is not cleared; entries are always
// written by a frame before they are read.
`include "modbus_read_response_checker_macros.svh"

module modbus_read_response_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  mrrc_rx_if.sink        rx_i,
  mrrc_cfg_if.sink       cfg_i,
  mrrc_res_if.source     res_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCrc   = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SLoad  = 3'd4;

  localparam int IdxW = mrrc_pkg::IdxW;
  localparam int CntW = mrrc_pkg::CntW;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] reg_count_q;
  logic [7:0]      byte_pos_q, slave_addr_q, func_code_q, count_byte_q, pending_high_q;
  logic [15:0]     window_q;
  logic [CntW-1:0] emit_pos_q;
  logic            eof_q;
  logic [IdxW-1:0] k_q, k_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_addr_q;
  logic [IdxW-1:0] out_index_q;
  logic [15:0]     out_value_q;
  logic [2:0]      out_status_q;
  logic            out_last_q;

  logic            rx_fire, in_data, buf_we, out_free, frame_clear;
  logic            load_err, load_word, word_last;
  logic [CntW-1:0] n_eff;
  logic [CntW:0]   two_n;
  logic [2:0]      status;
  logic [15:0]     rx_crc, crc_val, rdata;
  logic            crc_busy;
  mrrc_pkg::crc_ctrl_t crc_ctrl;

  assign rx_fire   = rx_i.valid && rx_i.ready;
  assign rx_i.ready = (state_q == SIdle);
  assign cfg_i.ready = 1'b1;
  assign n_eff     = mrrc_pkg::eff_count(reg_count_q);
  assign two_n     = {n_eff, 1'b0};
  assign out_free  = !out_valid_q || res_o.ready;

  // Data bytes sit at positions 3 .. 2+2N
  assign in_data = (byte_pos_q >= 8'd3)
                && ({1'b0, byte_pos_q} < (9'd3 + 9'(two_n)));
  assign buf_we  = rx_fire && in_data && !byte_pos_q[0] && (emit_pos_q < n_eff);

  // Feed the byte leaving the two-byte window into the CRC
  assign crc_ctrl.start = rx_fire && (byte_pos_q >= 8'd2);
  assign crc_ctrl.clear = frame_clear;
  assign crc_ctrl.data  = window_q[15:8];

  mrrc_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  mrrc_word_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (emit_pos_q[IdxW-1:0]),
    .wdata_i ({pending_high_q, rx_i.rx_byte}),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  // Check the finished frame; the first failing check wins
  assign rx_crc = {window_q[7:0], window_q[15:8]};
  always_comb begin
    priority if (byte_pos_q != (8'd5 + 8'(two_n))) begin
      status = mrrc_pkg::StBadLen;
    end else if (func_code_q != mrrc_pkg::FuncReadHolding) begin
      status = mrrc_pkg::StBadFunc;
    end else if (count_byte_q != 8'(two_n)) begin
      status = mrrc_pkg::StBadCount;
    end else if (rx_crc != crc_val) begin
      status = mrrc_pkg::StBadCrc;
    end else begin
      status = mrrc_pkg::StOk;
    end
  end

  assign word_last   = ((CntW'(k_q) + CntW'(1)) == n_eff);
  assign load_err    = (state_q == SCheck) && (status != mrrc_pkg::StOk) && out_free;
  assign load_word   = (state_q == SLoad) && out_free;
  assign frame_clear = load_err || (load_word && word_last);

  // Sequence byte intake, CRC, check and result emission
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      SIdle: begin
        if (rx_fire) begin
          if (byte_pos_q >= 8'd2) begin
            state_d = SCrc;
          end else if (rx_i.end_of_frame) begin
            state_d = SCheck;
          end
        end
      end
      SCrc: begin
        if (!crc_busy) begin
          state_d = eof_q ? SCheck : SIdle;
        end
      end
      SCheck: begin
        if (status == mrrc_pkg::StOk) begin
          k_d     = '0;
          state_d = SRead;
        end else if (load_err) begin
          state_d = SIdle;
        end
      end
      SRead: begin
        state_d = SLoad;
      end
      SLoad: begin
        if (load_word) begin
          if (word_last) begin
            state_d = SIdle;
          end else begin
            k_d     = k_q + IdxW'(1);
            state_d = SRead;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Hold a result until taken, refill from the sequencer
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_err || load_word) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      reg_count_q <= CntW'(1);
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        reg_count_q <= cfg_i.register_count;
      end
    end
  end

  // Advance per-frame state on each byte, drop it at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q     <= '0;
      slave_addr_q   <= '0;
      func_code_q    <= '0;
      count_byte_q   <= '0;
      pending_high_q <= '0;
      window_q       <= '0;
      emit_pos_q     <= '0;
      eof_q          <= 1'b0;
    end else if (frame_clear) begin
      byte_pos_q     <= '0;
      slave_addr_q   <= '0;
      func_code_q    <= '0;
      count_byte_q   <= '0;
      pending_high_q <= '0;
      window_q       <= '0;
      emit_pos_q     <= '0;
      eof_q          <= 1'b0;
    end else if (rx_fire) begin
      eof_q    <= rx_i.end_of_frame;
      window_q <= {window_q[7:0], rx_i.rx_byte};
      if (byte_pos_q != 8'hFF) begin
        byte_pos_q <= byte_pos_q + 8'd1;
      end
      if (byte_pos_q == 8'd0) begin
        slave_addr_q <= rx_i.rx_byte;
      end
      if (byte_pos_q == 8'd1) begin
        func_code_q <= rx_i.rx_byte;
      end
      if (byte_pos_q == 8'd2) begin
        count_byte_q <= rx_i.rx_byte;
      end
      if (in_data && byte_pos_q[0]) begin
        pending_high_q <= rx_i.rx_byte;
      end
      if (buf_we) begin
        emit_pos_q <= emit_pos_q + CntW'(1);
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load_err) begin
      out_addr_q   <= slave_addr_q;
      out_index_q  <= '0;
      out_value_q  <= '0;
      out_status_q <= status;
      out_last_q   <= 1'b1;
    end else if (load_word) begin
      out_addr_q   <= slave_addr_q;
      out_index_q  <= k_q;
      out_value_q  <= rdata;
      out_status_q <= mrrc_pkg::StOk;
      out_last_q   <= word_last;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.device_address = out_addr_q;
  assign res_o.register_index = out_index_q;
  assign res_o.register_value = out_value_q;
  assign res_o.status         = out_status_q;
  assign res_o.last           = out_last_q;

  `MRRC_ASSERT(err_result_closes_a, clk_i, rst_ni, out_valid_q && (out_status_q != mrrc_pkg::StOk), out_last_q && (out_index_q == '0) && (out_value_q == '0), "error result must be last with zero payload")
  `MRRC_ASSERT(crc_idle_a, clk_i, rst_ni, state_q == SIdle, !crc_busy, "CRC unit busy while idle")
  `MRRC_ASSERT_NEXT(clear_to_idle_a, clk_i, rst_ni, frame_clear, (state_q == SIdle) && (byte_pos_q == '0), "frame end did not return to idle")
  `MRRC_ASSERT(read_in_range_a, clk_i, rst_ni, (state_q == SRead) || (state_q == SLoad), CntW'(k_q) < n_eff, "word index beyond register count")

endmodule
